/* hw/rtl/ssa_pkg.sv */
// ----------------------------------------------------------------------------
// ssa_pkg
// Shared types and constants for the step sequencer advance block.
// ----------------------------------------------------------------------------
package ssa_pkg;

  localparam int MaxSteps   = 8;
  localparam int StepW      = 3;
  localparam int CountW     = 4;
  localparam int HoldW      = 4;
  localparam int ProbW      = 7;
  localparam int CfgIdxW    = 3;
  localparam int CfgDataW   = 56;
  localparam int InDataW    = 16;
  localparam int InUserW    = 2;
  localparam int OutDataW   = 8;

  localparam logic [ProbW-1:0] ProbAlways = 7'd100;

  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_STOP  = 2'd1,
    KIND_TICK  = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    MODE_FWD  = 2'd0,
    MODE_REV  = 2'd1,
    MODE_PEND = 2'd2,
    MODE_RAND = 2'd3
  } mode_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_STEP_COUNT = 3'd0,
    REG_PLAY_MODE  = 3'd1,
    REG_ENABLE     = 3'd2,
    REG_HOLD       = 3'd3,
    REG_PROB       = 3'd4
  } reg_idx_t;

  // controller -> datapath
  typedef struct packed {
    logic latch;
    logic eval;
    logic scan;
    logic load_out;
  } ssa_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic need_scan;
    logic scan_done;
  } ssa_stat_t;

endpackage

/* hw/rtl/ssa_ctrl.sv */
// ----------------------------------------------------------------------------
// ssa_ctrl
// Controller: sequences latch, evaluate, step scan and result hand-off.
// ----------------------------------------------------------------------------
module ssa_ctrl import ssa_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  output logic      out_tvalid,
  input  logic      out_tready,
  input  ssa_stat_t stat,
  output ssa_cmd_t  cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_SCAN,
    ST_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free   = !out_valid_r || out_tready;
  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cmd           = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.latch = 1'b1;
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd.eval  = 1'b1;
        state_nxt = stat.need_scan ? ST_SCAN : ST_DONE;
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_done) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* hw/rtl/ssa_dp.sv */
// ----------------------------------------------------------------------------
// ssa_dp
// Datapath: config registers, transport state, step scan and result register.
// ----------------------------------------------------------------------------
module ssa_dp import ssa_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_valid,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  input  logic [InDataW-1:0]  in_tdata,
  input  logic [InUserW-1:0]  in_tuser,
  output logic [OutDataW-1:0] out_tdata,
  input  ssa_cmd_t            cmd,
  output ssa_stat_t           stat
);

  // configuration
  logic [CountW-1:0]          step_count_r;
  mode_t                      play_mode_r;
  logic [MaxSteps-1:0]        enable_r;
  logic [MaxSteps*HoldW-1:0]  hold_codes_r;
  logic [MaxSteps*ProbW-1:0]  prob_table_r;

  // transport state
  logic             running_r;
  logic             first_r;
  logic [StepW-1:0] pos_r;
  logic             bounce_r;
  logic [HoldW-1:0] hold_r;

  // latched item
  kind_t            kind_r;
  logic [StepW-1:0] rstep_r;
  logic [ProbW-1:0] rpct_r;

  // scan
  logic [StepW-1:0] cand_r;
  logic [StepW-1:0] k_r;
  logic             back_r;

  // pending result
  logic             res_off_r, res_taken_r, res_fire_r;
  logic [OutDataW-1:0] out_r;

  logic [CountW-1:0] count;
  logic [StepW-1:0]  last;
  logic [StepW-1:0]  cur;
  logic [StepW-1:0]  mode_nxt;
  logic              mode_back;
  logic              bounce_nxt;
  logic              is_sel_tick;
  logic              hit;
  logic              scan_end;
  logic [StepW-1:0]  cand_adv;
  logic [ProbW-1:0]  cand_prob;
  logic [HoldW-1:0]  cand_hold;

  always_comb begin
    if (step_count_r == '0) count = CountW'(1);
    else if (step_count_r > CountW'(MaxSteps)) count = CountW'(MaxSteps);
    else count = step_count_r;
  end

  assign last = StepW'(count - CountW'(1));
  assign cur  = ({1'b0, pos_r} >= count) ? last : pos_r;

  // next step by play mode, before skipping disabled steps
  always_comb begin
    mode_nxt   = '0;
    mode_back  = 1'b0;
    bounce_nxt = bounce_r;
    unique case (play_mode_r)
      MODE_FWD: mode_nxt = (cur == last) ? '0 : cur + StepW'(1);
      MODE_REV: begin
        mode_nxt  = (cur == '0) ? last : cur - StepW'(1);
        mode_back = 1'b1;
      end
      MODE_PEND: begin
        if (count <= CountW'(1)) begin
          mode_nxt = '0;
        end else if (!bounce_r) begin
          if (cur == last) begin
            mode_nxt   = last - StepW'(1);
            bounce_nxt = 1'b1;
          end else begin
            mode_nxt = cur + StepW'(1);
          end
          mode_back = bounce_nxt;
        end else begin
          if (cur == '0) begin
            mode_nxt   = StepW'(1);
            bounce_nxt = 1'b0;
          end else begin
            mode_nxt = cur - StepW'(1);
          end
          mode_back = bounce_nxt;
        end
      end
      MODE_RAND: mode_nxt = (rstep_r > last) ? last : rstep_r;
      default: mode_nxt = '0;
    endcase
  end

  assign is_sel_tick = (kind_r == KIND_TICK) && running_r && (first_r || hold_r == '0);

  assign hit       = enable_r[cand_r];
  assign scan_end  = hit || (k_r == last);
  assign cand_adv  = back_r ? ((cand_r == '0) ? last : cand_r - StepW'(1))
                            : ((cand_r == last) ? '0 : cand_r + StepW'(1));
  assign cand_prob = prob_table_r[cand_r*ProbW +: ProbW];
  assign cand_hold = hold_codes_r[cand_r*HoldW +: HoldW];

  assign stat.need_scan = is_sel_tick;
  assign stat.scan_done = scan_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_count_r <= CountW'(MaxSteps);
      play_mode_r  <= MODE_FWD;
      enable_r     <= '1;
      hold_codes_r <= '0;
      prob_table_r <= '0;
      running_r    <= 1'b0;
      first_r      <= 1'b0;
      pos_r        <= '0;
      bounce_r     <= 1'b0;
      hold_r       <= '0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_STEP_COUNT: step_count_r <= cfg_data[CountW-1:0];
          REG_PLAY_MODE:  play_mode_r  <= mode_t'(cfg_data[1:0]);
          REG_ENABLE:     enable_r     <= cfg_data[MaxSteps-1:0];
          REG_HOLD:       hold_codes_r <= cfg_data[MaxSteps*HoldW-1:0];
          REG_PROB:       prob_table_r <= cfg_data[MaxSteps*ProbW-1:0];
          default: ;
        endcase
      end
      if (cmd.eval) begin
        unique case (kind_r)
          KIND_START: begin
            pos_r     <= '0;
            bounce_r  <= 1'b0;
            first_r   <= 1'b1;
            hold_r    <= '0;
            running_r <= 1'b1;
          end
          KIND_STOP: begin
            running_r <= 1'b0;
            pos_r     <= '0;
            first_r   <= 1'b0;
            hold_r    <= '0;
          end
          KIND_TICK: begin
            if (running_r) begin
              if (!first_r && hold_r != '0) hold_r <= hold_r - HoldW'(1);
              else if (first_r) first_r <= 1'b0;
              else bounce_r <= bounce_nxt;
            end
          end
          default: ;
        endcase
      end
      if (cmd.scan && hit) begin
        pos_r  <= cand_r;
        hold_r <= cand_hold;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      kind_r  <= kind_t'(in_tuser);
      rstep_r <= in_tdata[StepW-1:0];
      rpct_r  <= in_tdata[StepW +: ProbW];
    end
    if (cmd.eval) begin
      res_off_r   <= (kind_r == KIND_STOP) || is_sel_tick;
      res_taken_r <= 1'b0;
      res_fire_r  <= 1'b0;
      k_r         <= '0;
      if (first_r) begin
        cand_r <= '0;
        back_r <= 1'b0;
      end else begin
        cand_r <= mode_nxt;
        back_r <= mode_back;
      end
    end
    if (cmd.scan) begin
      if (hit) begin
        res_taken_r <= 1'b1;
        res_fire_r  <= (cand_prob >= ProbAlways) || (rpct_r < cand_prob);
      end else begin
        cand_r <= cand_adv;
        k_r    <= k_r + StepW'(1);
      end
    end
    if (cmd.load_out) begin
      out_r <= {1'b0, running_r, res_fire_r, pos_r, res_taken_r, res_off_r};
    end
  end

  assign out_tdata = out_r;

endmodule

/* hw/rtl/step_sequencer_advance_top.sv */
// ----------------------------------------------------------------------------
// step_sequencer_advance_top
// Step sequencer transport: start/stop/tick events, four play modes.
// ----------------------------------------------------------------------------
// Flow: each accepted beat is latched, evaluated and loaded into the result
// register; a step-selecting tick first scans 1..8 steps, one step per cycle.
// Throughput: one beat at a time; the next beat is accepted the cycle after the
// result is loaded, and loading waits while out_tvalid is held without out_tready.
// Reset: synchronous rst_n restores register defaults and the stopped state.
module step_sequencer_advance_top import ssa_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  // config write channel
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  // input stream
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [InDataW-1:0]  in_tdata,   // [2:0] random_step, [9:3] random_percent
  input  logic [InUserW-1:0]  in_tuser,   // [1:0] kind
  // result stream
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [OutDataW-1:0] out_tdata   // [0] notes_off, [1] step_taken,
                                          // [4:2] step_index, [5] fire, [6] running
);

  ssa_cmd_t  cmd;
  ssa_stat_t stat;

  assign cfg_ready = 1'b1;

  ssa_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  ssa_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tdata (out_tdata),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule
